>>> src/tsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared mode codes, fill byte and the classified item carried between the
// front end and the execution back end of the text screen buffer.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_CURSOR = 2'd1;
  localparam logic [1:0] MODE_WRITE  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [7:0] BLANK = 8'h20;
  localparam logic [7:0] NUL   = 8'h00;

  typedef struct packed {
    logic [1:0] mode;
    logic       in_range;   // row and col both on screen
    logic       has_char;   // char_code is not the terminator
    logic       start;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] char_code;
  } item_t;

endpackage

>>> src/tsb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_front
// Accepts input beats, range-checks the cell coordinates and flags the
// terminator byte, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module tsb_front #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic           item_valid,
  output logic           item_ready,
  input  logic [1:0]     mode,
  input  logic [7:0]     row,
  input  logic [7:0]     col,
  input  logic [7:0]     char_code,
  input  logic           string_start,
  input  logic           q_full,
  output logic           push,
  output tsb_pkg::item_t push_item
);

  localparam logic [7:0] ROWS_B = 8'(ROWS);
  localparam logic [7:0] COLS_B = 8'(COLS);

  assign item_ready = !q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    push_item.mode      = mode;
    push_item.in_range  = (row < ROWS_B) && (col < COLS_B);
    push_item.has_char  = (char_code != tsb_pkg::NUL);
    push_item.start     = string_start;
    push_item.row       = row;
    push_item.col       = col;
    push_item.char_code = char_code;
  end

endmodule

>>> src/tsb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_queue
// Two-entry FIFO of classified items between front and back, so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module tsb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsb_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tsb_pkg::item_t head
);

  tsb_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/tsb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_back
// Executes queued items against the cell store: cursor moves, character
// writes with scroll, cell reads, and fill sweeps for clear, scroll and reset.
// Rows are held as a ring; a scroll advances the top-row base pointer and
// blanks the physical row that becomes the new bottom row.
// ----------------------------------------------------------------------------
module tsb_back #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  tsb_pkg::item_t head,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [7:0]     read_char,
  output logic           status
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  // screen store
  logic [7:0]    mem [CELLS];
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic          re;
  logic [AW-1:0] ra;

  // architectural state
  logic [RW-1:0] base, base_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] wrow, wrow_next;
  logic [CW-1:0] wcol, wcol_next;

  // fill sweep
  logic          busy, busy_next;
  logic [AW-1:0] sw_addr, sw_addr_next;
  logic [AW-1:0] sw_last, sw_last_next;
  logic          sw_scroll, sw_scroll_next;

  // result pipe
  logic          p1_valid, p1_valid_next;
  logic          p1_read, p1_read_next;
  logic          p1_status, p1_status_next;
  logic          adv;
  logic          can_issue;
  logic [RW-1:0] pos_row;
  logic [CW-1:0] pos_col;
  logic [AW-1:0] base_addr;

  function automatic logic [AW-1:0] phys(logic [RW-1:0] r, logic [CW-1:0] c,
                                         logic [RW-1:0] b);
    logic [RW:0] s;
    begin
      s = {1'b0, r} + {1'b0, b};
      if (s >= (RW+1)'(ROWS)) begin
        s = s - (RW+1)'(ROWS);
      end
      return AW'(s) * AW'(COLS) + AW'(c);
    end
  endfunction

  assign adv       = !result_valid || result_ready;
  assign can_issue = !busy && !q_empty && (!p1_valid || adv);
  assign pop       = can_issue;
  assign pos_row   = head.start ? cur_row : wrow;
  assign pos_col   = head.start ? cur_col : wcol;
  assign base_addr = AW'(base) * AW'(COLS);

  always_comb begin
    we             = 1'b0;
    wa             = phys(pos_row, pos_col, base);
    wd             = head.char_code;
    re             = 1'b0;
    ra             = phys(head.row[RW-1:0], head.col[CW-1:0], base);
    base_next      = base;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    wrow_next      = wrow;
    wcol_next      = wcol;
    busy_next      = busy;
    sw_addr_next   = sw_addr;
    sw_last_next   = sw_last;
    sw_scroll_next = sw_scroll;
    p1_valid_next  = p1_valid;
    p1_read_next   = p1_read;
    p1_status_next = p1_status;

    if (busy) begin
      we = 1'b1;
      wa = sw_addr;
      wd = tsb_pkg::BLANK;
      if (sw_addr == sw_last) begin
        busy_next = 1'b0;
        if (sw_scroll) begin
          base_next = (base == RW'(ROWS - 1)) ? '0 : base + RW'(1);
        end
      end else begin
        sw_addr_next = sw_addr + AW'(1);
      end
    end

    if (can_issue) begin
      p1_valid_next  = 1'b1;
      p1_read_next   = (head.mode == tsb_pkg::MODE_READ) && head.in_range;
      p1_status_next = ((head.mode == tsb_pkg::MODE_CURSOR) ||
                        (head.mode == tsb_pkg::MODE_READ)) && !head.in_range;
      case (head.mode)
        tsb_pkg::MODE_CLEAR: begin
          busy_next      = 1'b1;
          sw_addr_next   = '0;
          sw_last_next   = AW'(CELLS - 1);
          sw_scroll_next = 1'b0;
        end
        tsb_pkg::MODE_CURSOR: begin
          if (head.in_range) begin
            cur_row_next = head.row[RW-1:0];
            cur_col_next = head.col[CW-1:0];
          end
        end
        tsb_pkg::MODE_WRITE: begin
          wrow_next = pos_row;
          wcol_next = pos_col;
          if (head.has_char) begin
            we = 1'b1;
            if (pos_col == CW'(COLS - 1)) begin
              wcol_next = '0;
              if (pos_row == RW'(ROWS - 1)) begin
                // ran off the last cell: stay on the bottom row and scroll
                busy_next      = 1'b1;
                sw_addr_next   = base_addr;
                sw_last_next   = base_addr + AW'(COLS - 1);
                sw_scroll_next = 1'b1;
              end else begin
                wrow_next = pos_row + RW'(1);
              end
            end else begin
              wcol_next = pos_col + CW'(1);
            end
          end
        end
        tsb_pkg::MODE_READ: begin
          re = head.in_range;
        end
        default: begin
        end
      endcase
    end else if (adv) begin
      p1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_char <= p1_read ? rdata : tsb_pkg::NUL;
      status    <= p1_status;
    end
    p1_read   <= p1_read_next;
    p1_status <= p1_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;     // reset fill pass over the whole store
      sw_addr      <= '0;
      sw_last      <= AW'(CELLS - 1);
      sw_scroll    <= 1'b0;
      base         <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      wrow         <= '0;
      wcol         <= '0;
      p1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      sw_addr   <= sw_addr_next;
      sw_last   <= sw_last_next;
      sw_scroll <= sw_scroll_next;
      base      <= base_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      wrow      <= wrow_next;
      wcol      <= wcol_next;
      p1_valid  <= p1_valid_next;
      if (adv) begin
        result_valid <= p1_valid;
      end
    end
  end

endmodule

>>> src/text_screen_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_buffer_core
// Character-cell screen store with cursor, running write offset and
// one-row scroll, built as a classifying front end, a short item queue and
// an execution back end that owns the store.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  item     | item_valid / item_ready   | mode, row, col, char_code,
//           |                           | string_start
//  result   | result_valid/result_ready | read_char, status
//
//  Cursor, write and read beats issue one per cycle while no fill sweep runs
//  and results are taken; each result comes out behind a registered store
//  read and an output register. Clear walks the store at one cell a cycle.
//  A write that runs off the last cell blanks one row.
//  After reset the same fill pass runs over the whole store before any beat
//  issues; the queue still takes up to two beats meanwhile.
//  A stalled result holds the back end; the front keeps accepting until the
//  queue is full.
// ----------------------------------------------------------------------------
module text_screen_buffer_core #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] mode,
  input  logic [7:0] row,
  input  logic [7:0] col,
  input  logic [7:0] char_code,
  input  logic       string_start,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] read_char,
  output logic       status
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  tsb_pkg::item_t push_item;
  tsb_pkg::item_t head;

  tsb_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .mode        (mode),
    .row         (row),
    .col         (col),
    .char_code   (char_code),
    .string_start(string_start),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  tsb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  tsb_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .read_char   (read_char),
    .status      (status)
  );

endmodule

>>> dv/text_screen_buffer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_buffer_core_tb
// Self-checking bench for the text screen buffer. A scoreboard object keeps
// its own screen, cursor and write offset and predicts the read_char/status
// of every accepted beat. Stimulus opens with reset contents, range edges,
// a scroll and the terminator byte. It then moves to random cursor-and-string
// runs, long write runs that scroll, read-backs, rare clears and noise.
// Both sides idle in random bursts, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module text_screen_buffer_core_tb;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int ITEMS       = 1450;
  localparam int CALM_ITEMS  = 150;   // tail of the run with no idling
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 20000; // clear walk covers all ROWS*COLS cells
  localparam int DRAIN       = 50;

  typedef struct packed {
    logic [7:0] read_char;
    logic       status;
  } cell_result_t;

  class screen_scoreboard;
    localparam int ROWS  = SCREEN_ROWS;
    localparam int COLS  = SCREEN_COLS;
    localparam int CELLS = ROWS * COLS;

    logic [7:0]   cells [CELLS];
    int unsigned  cur_row;
    int unsigned  cur_col;
    int unsigned  offset;
    cell_result_t expected_q [$];
    int           errors;

    function new();
      foreach (cells[i]) cells[i] = tsb_pkg::BLANK;
      cur_row = 0;
      cur_col = 0;
      offset  = 0;
      errors  = 0;
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [1:0] m, logic [7:0] r, logic [7:0] c,
                            logic [7:0] ch, logic s);
      cell_result_t exp_res;
      logic         on_screen;
      exp_res   = '0;
      on_screen = (r < ROWS) && (c < COLS);
      case (m)
        tsb_pkg::MODE_CLEAR: begin
          foreach (cells[i]) cells[i] = tsb_pkg::BLANK;
        end
        tsb_pkg::MODE_CURSOR: begin
          if (on_screen) begin
            cur_row = r;
            cur_col = c;
          end else begin
            exp_res.status = 1'b1;
          end
        end
        tsb_pkg::MODE_WRITE: begin
          if (s) offset = cur_row * COLS + cur_col;
          if (ch != tsb_pkg::NUL) begin
            if (offset >= CELLS) offset = 0;
            cells[offset] = ch;
            offset++;
            if (offset >= CELLS) begin
              // scroll up one row, bottom row blanked
              offset = (ROWS - 1) * COLS;
              for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
              for (int i = (ROWS - 1) * COLS; i < CELLS; i++) cells[i] = tsb_pkg::BLANK;
            end
          end
        end
        default: begin
          if (on_screen) exp_res.read_char = cells[r * COLS + c];
          else           exp_res.status = 1'b1;
        end
      endcase
      expected_q.push_back(exp_res);
    endfunction

    task check_result(logic [7:0] rd, logic st);
      cell_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with nothing expected (read_char %02h status %b)",
                         rd, st));
        return;
      end
      exp_res = expected_q.pop_front();
      if (rd !== exp_res.read_char)
        report($sformatf("read_char %02h, expected %02h", rd, exp_res.read_char));
      if (st !== exp_res.status)
        report($sformatf("status %b, expected %b", st, exp_res.status));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  logic [1:0] mode;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] char_code;
  logic       string_start;
  logic       result_valid;
  logic       result_ready;
  logic [7:0] read_char;
  logic       status;

  screen_scoreboard sb = new();

  int items_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  text_screen_buffer_core #(
    .ROWS(SCREEN_ROWS),
    .COLS(SCREEN_COLS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .row          (row),
    .col          (col),
    .char_code    (char_code),
    .string_start (string_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .read_char    (read_char),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitors see pre-edge values, as all drives are nonblocking
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready)
      sb.note_item(mode, row, col, char_code, string_start);
    if (!rst && result_valid && result_ready)
      sb.check_result(read_char, status);
  end

  always @(posedge clk) begin
    if (!rst && ((item_valid && item_ready) || (result_valid && result_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_item(logic [1:0] m, logic [7:0] r, logic [7:0] c,
                           logic [7:0] ch, logic s);
    if (!calm && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    mode         <= m;
    row          <= r;
    col          <= c;
    char_code    <= ch;
    string_start <= s;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int         pick;
    int         len;
    int         cr;
    int         cc;
    bit         hold_done;
    logic [1:0] m;
    logic [7:0] ch;

    hold_done = 1'b0;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    mode         <= tsb_pkg::MODE_CLEAR;
    row          <= '0;
    col          <= '0;
    char_code    <= tsb_pkg::NUL;
    string_start <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset contents and range edges
    send_item(tsb_pkg::MODE_READ,   8'd0,   8'd0,   8'hFF, 1'b1);
    send_item(tsb_pkg::MODE_READ,   8'd24,  8'd79,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd25,  8'd0,   8'h00, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd0,   8'd80,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'hFF,  8'hFF,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_CURSOR, 8'd25,  8'd0,   8'h00, 1'b0);
    send_item(tsb_pkg::MODE_CURSOR, 8'd0,   8'd80,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_CURSOR, 8'hFF,  8'hFF,  8'hFF, 1'b1);
    // two cells before the end, the second write scrolls
    send_item(tsb_pkg::MODE_CURSOR, 8'd24,  8'd78,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_WRITE,  8'hFF,  8'hFF,  8'h41, 1'b1);
    send_item(tsb_pkg::MODE_WRITE,  8'h00,  8'h00,  8'h42, 1'b0);
    send_item(tsb_pkg::MODE_WRITE,  8'h00,  8'h00,  8'h43, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd23,  8'd78,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd23,  8'd79,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd24,  8'd0,   8'h00, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd24,  8'd1,   8'h00, 1'b0);
    // terminator still restarts the offset at the cursor
    send_item(tsb_pkg::MODE_WRITE,  8'h00,  8'h00,  tsb_pkg::NUL, 1'b1);
    send_item(tsb_pkg::MODE_WRITE,  8'h00,  8'h00,  8'hFF, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd24,  8'd78,  8'h00, 1'b0);
    send_item(tsb_pkg::MODE_CURSOR, 8'd0,   8'd0,   8'h00, 1'b0);
    send_item(tsb_pkg::MODE_WRITE,  8'h00,  8'h00,  8'h01, 1'b1);
    send_item(tsb_pkg::MODE_READ,   8'd0,   8'd0,   8'h00, 1'b0);
    // clear keeps cursor and offset
    send_item(tsb_pkg::MODE_CLEAR,  8'hFF,  8'hFF,  8'hFF, 1'b1);
    send_item(tsb_pkg::MODE_WRITE,  8'h00,  8'h00,  8'h7F, 1'b0);
    send_item(tsb_pkg::MODE_READ,   8'd0,   8'd1,   8'h00, 1'b0);

    while (items_sent < ITEMS) begin
      if (items_sent >= ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        send_item(tsb_pkg::MODE_CLEAR, any_byte(), any_byte(), any_byte(),
                  1'($urandom_range(0, 1)));
      end else if (pick < 10) begin
        case ($urandom_range(0, 2))
          0:       m = tsb_pkg::MODE_CURSOR;
          1:       m = tsb_pkg::MODE_WRITE;
          default: m = tsb_pkg::MODE_READ;
        endcase
        send_item(m, any_byte(), any_byte(), any_byte(), 1'($urandom_range(0, 1)));
      end else if (pick < 60) begin
        // cursor, then a string, then read back around it
        cr = $urandom_range(0, 1) ? SCREEN_ROWS - 1 : $urandom_range(0, SCREEN_ROWS - 1);
        cc = $urandom_range(0, SCREEN_COLS - 1);
        send_item(tsb_pkg::MODE_CURSOR, 8'(cr), 8'(cc), any_byte(),
                  1'($urandom_range(0, 1)));
        len = $urandom_range(1, 20);
        for (int k = 0; k < len; k++) begin
          ch = ($urandom_range(0, 15) == 0) ? tsb_pkg::NUL : 8'($urandom_range(1, 255));
          send_item(tsb_pkg::MODE_WRITE, any_byte(), any_byte(), ch, k == 0);
        end
        for (int k = 0; k < 3; k++) begin
          send_item(tsb_pkg::MODE_READ, 8'($urandom_range(0, 1) && cr > 0 ? cr - 1 : cr),
                    8'((cc + k) % SCREEN_COLS), any_byte(), 1'($urandom_range(0, 1)));
        end
      end else if (pick < 80) begin
        // long run from the current offset, often crossing the end
        len = $urandom_range(10, 40);
        for (int k = 0; k < len; k++) begin
          ch = 8'($urandom_range(1, 255));
          send_item(tsb_pkg::MODE_WRITE, any_byte(), any_byte(), ch,
                    $urandom_range(0, 19) == 0);
        end
      end else begin
        if ($urandom_range(0, 7) == 0)
          send_item(tsb_pkg::MODE_READ, any_byte(), any_byte(), any_byte(),
                    1'($urandom_range(0, 1)));
        else
          send_item(tsb_pkg::MODE_READ, 8'($urandom_range(0, SCREEN_ROWS - 1)),
                    8'($urandom_range(0, SCREEN_COLS - 1)), any_byte(),
                    1'($urandom_range(0, 1)));
      end
    end
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
src/tsb_pkg.sv
src/tsb_front.sv
src/tsb_queue.sv
src/tsb_back.sv
src/text_screen_buffer_core.sv
dv/text_screen_buffer_core_tb.sv
